@@ hdl/ibma_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ibma_pkg - shared types and constants of the inode bitmap allocator
// Map geometry, status codes, request/result structs and the FSM encoding.
// ----------------------------------------------------------------------------
package ibma_pkg;

  localparam int unsigned MAP_WORDS        = 32;
  localparam int unsigned WORD_BITS        = 32;
  localparam int unsigned TOP_BIT          = 31;
  localparam int unsigned SLOT_W           = 10;
  localparam int unsigned FREE_W           = 11;
  localparam int unsigned SLOT_FIELD_LIMIT = 1024;
  localparam int unsigned BIT_W            = $clog2(WORD_BITS);

  // only slots that the slot field can name take part
  localparam int unsigned USED_WORDS =
    (MAP_WORDS * WORD_BITS > SLOT_FIELD_LIMIT) ? SLOT_FIELD_LIMIT / WORD_BITS : MAP_WORDS;
  localparam int unsigned SLOT_TOTAL = USED_WORDS * WORD_BITS;
  localparam int unsigned WIDX_W     = (USED_WORDS > 1) ? $clog2(USED_WORDS) : 1;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_ALREADY_FREE = 2'd1,
    ST_FULL         = 2'd2,
    ST_REFUSED      = 2'd3
  } status_e;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [SLOT_W-1:0] slot;
  } req_t;

  typedef struct packed {
    status_e           status;
    logic [SLOT_W-1:0] granted_slot;
    logic [FREE_W-1:0] free_slots;
  } rsp_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EVAL = 3'b010,
    S_RESP = 3'b100
  } state_e;

endpackage
`default_nettype wire

@@ hdl/ibma_ffz.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ibma_ffz - find first zero in one map word
// Scans from bit 31 down; idx_o is the offset from bit 31 of the first clear bit.
// ----------------------------------------------------------------------------
module ibma_ffz (
  input  wire logic [ibma_pkg::WORD_BITS-1:0] word_i,
  output logic                                found_o,
  output logic [ibma_pkg::BIT_W-1:0]          idx_o
);

  localparam int unsigned WordBits = ibma_pkg::WORD_BITS;
  localparam int unsigned BitW     = ibma_pkg::BIT_W;

  always_comb begin
    found_o = 1'b0;
    idx_o   = '0;
    // walk upward so the highest clear position (lowest offset) wins
    for (int i = 0; i < WordBits; i++) begin
      if (!word_i[i]) begin
        found_o = 1'b1;
        idx_o   = BitW'(WordBits - 1 - i);
      end
    end
  end

endmodule
`default_nettype wire

@@ hdl/inode_bitmap_allocator.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// inode_bitmap_allocator - first-zero bitmap allocator for object slots
// Usage map in a one-read/one-write word memory; allocate scans words in
// order, free clears one bit. Keeps the free slot count.
// ----------------------------------------------------------------------------
//   channel | dir | handshake                  | payload
//   --------+-----+----------------------------+---------------------------
//   in      | in  | in_valid_i / in_stall_o    | ibma_pkg::req_t in_data_i
//   out     | out | out_valid_o / out_stall_i  | ibma_pkg::rsp_t out_data_o
//
// One request at a time. Refused requests and allocate with a zero free
// count go straight to the response state; a free does one map read.
// An allocate reads words in order from word 0 until one has a clear bit,
// at most USED_WORDS reads. Reset clears the per-word valid bits at once,
// so no clearing pass is needed. A stalled result holds in the output
// register; the next request waits in the response state.
// ----------------------------------------------------------------------------
module inode_bitmap_allocator (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  input  wire ibma_pkg::req_t in_data_i,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  output ibma_pkg::rsp_t      out_data_o
);

  localparam int unsigned WordBits  = ibma_pkg::WORD_BITS;
  localparam int unsigned UsedWords = ibma_pkg::USED_WORDS;
  localparam int unsigned WidxW     = ibma_pkg::WIDX_W;
  localparam int unsigned BitW      = ibma_pkg::BIT_W;
  localparam int unsigned SlotW     = ibma_pkg::SLOT_W;
  localparam int unsigned FreeW     = ibma_pkg::FREE_W;
  localparam int unsigned SlotTotal = ibma_pkg::SLOT_TOTAL;

  // map memory and per-word valid bits (invalid word reads as all free)
  logic [WordBits-1:0] mem_q [UsedWords];
  logic [UsedWords-1:0] word_vld_q;
  logic [WordBits-1:0] rdata_q;
  logic                rvld_q;

  ibma_pkg::state_e    state_q, state_d;
  ibma_pkg::op_e       op_q, op_d;
  logic [BitW-1:0]     bit_q, bit_d;
  logic [WidxW-1:0]    widx_q, widx_d;
  logic [FreeW-1:0]    free_q, free_d;
  ibma_pkg::rsp_t      res_q, res_d;
  ibma_pkg::rsp_t      out_q;
  logic                out_valid_q;

  logic                rd_en;
  logic [WidxW-1:0]    rd_addr;
  logic                wr_en;
  logic [WordBits-1:0] wdata;
  logic [WordBits-1:0] word;
  logic                ffz_found;
  logic [BitW-1:0]     ffz_idx;
  logic                accept;
  logic                out_free;
  logic                slot_bad;

  assign word     = rvld_q ? rdata_q : '0;
  assign accept   = in_valid_i && (state_q == ibma_pkg::S_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;
  assign slot_bad = (in_data_i.slot == '0) || (32'(in_data_i.slot) >= SlotTotal);

  ibma_ffz u_ffz (
    .word_i  (word),
    .found_o (ffz_found),
    .idx_o   (ffz_idx)
  );

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    bit_d   = bit_q;
    widx_d  = widx_q;
    free_d  = free_q;
    res_d   = res_q;
    rd_en   = 1'b0;
    rd_addr = widx_q;
    wr_en   = 1'b0;
    wdata   = word;
    case (state_q)
      ibma_pkg::S_IDLE: begin
        if (accept) begin
          op_d  = in_data_i.op;
          bit_d = in_data_i.slot[BitW-1:0];
          res_d = '{status: ibma_pkg::ST_OK, granted_slot: '0, free_slots: free_q};
          if (in_data_i.op == ibma_pkg::OP_ALLOC) begin
            if (free_q == '0) begin
              res_d.status = ibma_pkg::ST_FULL;
              state_d      = ibma_pkg::S_RESP;
            end else begin
              widx_d  = '0;
              rd_en   = 1'b1;
              rd_addr = '0;
              state_d = ibma_pkg::S_EVAL;
            end
          end else if (slot_bad) begin
            res_d.status = ibma_pkg::ST_REFUSED;
            state_d      = ibma_pkg::S_RESP;
          end else begin
            widx_d  = WidxW'(in_data_i.slot >> BitW);
            rd_en   = 1'b1;
            rd_addr = widx_d;
            state_d = ibma_pkg::S_EVAL;
          end
        end
      end
      ibma_pkg::S_EVAL: begin
        if (op_q == ibma_pkg::OP_ALLOC) begin
          if (ffz_found) begin
            wr_en   = 1'b1;
            wdata   = word | (WordBits'(1) << (~ffz_idx));
            if (free_q != '0) free_d = free_q - 1'b1;
            res_d   = '{status: ibma_pkg::ST_OK,
                        granted_slot: SlotW'({widx_q, ffz_idx}),
                        free_slots: free_d};
            state_d = ibma_pkg::S_RESP;
          end else if (32'(widx_q) == UsedWords - 1) begin
            res_d.status = ibma_pkg::ST_FULL;
            state_d      = ibma_pkg::S_RESP;
          end else begin
            // word full: fetch the next one
            widx_d  = WidxW'(widx_q + 1'b1);
            rd_en   = 1'b1;
            rd_addr = widx_d;
          end
        end else begin
          if (!word[~bit_q]) begin
            res_d.status = ibma_pkg::ST_ALREADY_FREE;
          end else begin
            wr_en = 1'b1;
            wdata = word & ~(WordBits'(1) << (~bit_q));
            if (32'(free_q) < SlotTotal) free_d = free_q + 1'b1;
            res_d.free_slots = free_d;
          end
          state_d = ibma_pkg::S_RESP;
        end
      end
      ibma_pkg::S_RESP: begin
        if (out_free) state_d = ibma_pkg::S_IDLE;
      end
      default: state_d = ibma_pkg::S_IDLE;
    endcase
  end

  // map memory: one read and one write port, registered read data
  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[widx_q] <= wdata;
    if (rd_en) rdata_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_vld_q <= '0;
      rvld_q     <= 1'b0;
    end else begin
      if (wr_en) word_vld_q[widx_q] <= 1'b1;
      if (rd_en) rvld_q <= word_vld_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ibma_pkg::S_IDLE;
      free_q      <= FreeW'(SlotTotal);
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      free_q  <= free_d;
      if (state_q == ibma_pkg::S_RESP && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    bit_q  <= bit_d;
    widx_q <= widx_d;
    res_q  <= res_d;
    if (state_q == ibma_pkg::S_RESP && out_free) out_q <= res_q;
  end

  assign in_stall_o  = (state_q != ibma_pkg::S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

@@ hdl/ibma_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ibma_checker - port-level checks for the inode bitmap allocator
// Channels hold under stall, one request at a time, result fields consistent.
// ----------------------------------------------------------------------------
module ibma_checker (
  input wire logic           clk_i,
  input wire logic           rst_ni,
  input wire logic           in_valid_i,
  input wire logic           in_stall_o,
  input wire ibma_pkg::req_t in_data_i,
  input wire logic           out_valid_o,
  input wire logic           out_stall_i,
  input wire ibma_pkg::rsp_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result dropped or changed");

  a_grant_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status != ibma_pkg::ST_OK || out_data_o.granted_slot == '0)
    |-> out_data_o.granted_slot == '0 || out_data_o.status == ibma_pkg::ST_OK)
    else $error("granted slot set on a failed request");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> 32'(out_data_o.free_slots) <= ibma_pkg::SLOT_TOTAL)
    else $error("free count out of range");

  a_full_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == ibma_pkg::ST_FULL |-> out_data_o.free_slots == '0)
    else $error("full reported with free slots left");

  // one request in flight: a taken request stalls the next one
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second request taken while one is in flight");

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(in_data_i))
    else $error("stalled request dropped or changed");

endmodule

bind inode_bitmap_allocator ibma_checker u_ibma_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
`default_nettype wire
